>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared constants, codes and control types of the lifo stack allocator
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int BUFFER_BYTES_DEF = 65536;
  localparam int HEADER_BYTES_DEF = 8;

  localparam int LEN_W = 17;   // lengths, offsets, capacity, top index
  localparam int OFF_W = 18;   // signed slice offset
  localparam int CODE_W = 2;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [LEN_W-1:0] CAP_RESET = 17'h10000;

  typedef enum logic [CODE_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_RESIZE = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_code_t;

  typedef enum logic [CODE_W-1:0] {
    STS_OK       = 2'd0,
    STS_NO_ROOM  = 2'd1,
    STS_NOT_OWN  = 2'd2,
    STS_NOT_LAST = 2'd3
  } sts_code_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // word accepted, latch it and read its header
    logic exec;    // apply the command and load the result register
    logic clear;   // header store clearing sweep step
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } dp_sts_t;

endpackage

>>> rtl/lsa_ctrl.sv
// ----------------------------------------------------------------------------
// lsa_ctrl
// Sequencer: header store sweep after reset, accept, execute, result handoff
// ----------------------------------------------------------------------------
module lsa_ctrl import lsa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t dp_sts,
  output dp_cmd_t dp_cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    dp_cmd.load  = 1'b0;
    dp_cmd.exec  = 1'b0;
    dp_cmd.clear = 1'b0;
    in_tready    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        dp_cmd.clear = 1'b1;
        if (dp_sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take the word
        if (slot_free) begin
          dp_cmd.exec = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (dp_cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> rtl/lsa_dp.sv
// ----------------------------------------------------------------------------
// lsa_dp
// Datapath: capacity register, stack top, header store and result register
// ----------------------------------------------------------------------------
module lsa_dp import lsa_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  dp_cmd_t           dp_cmd,
  output dp_sts_t           dp_sts,
  input  logic [CODE_W-1:0] in_cmd,
  input  logic [LEN_W-1:0]  in_slice_size,
  input  logic [OFF_W-1:0]  in_slice_offset,
  output logic [CODE_W-1:0] out_status,
  output logic [LEN_W-1:0]  out_data_offset,
  output logic [LEN_W-1:0]  out_top_index
);

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int LIM_INT = (BUFFER_BYTES > 131071) ? 131071 : BUFFER_BYTES;
  localparam logic [LEN_W-1:0] CAP_LIM = LEN_W'(LIM_INT);
  localparam logic [LEN_W-1:0] HDR = LEN_W'(HEADER_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(BUFFER_BYTES - 1);

  logic [LEN_W-1:0] hdr_mem [BUFFER_BYTES];

  logic [LEN_W-1:0]  cap_r, cap_nxt;
  logic [LEN_W-1:0]  top_r, top_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [LEN_W-1:0]  rdata_r;
  logic [CODE_W-1:0] cmd_r;
  logic [LEN_W-1:0]  size_r;
  logic [OFF_W-1:0]  off_r;
  logic [CODE_W-1:0] status_r;
  logic [LEN_W-1:0]  data_r;
  logic [LEN_W-1:0]  top_out_r;

  logic [LEN_W-1:0]  cap;
  logic [LEN_W-1:0]  off_u;
  logic [LEN_W+1:0]  alloc_sum;
  logic [LEN_W:0]    chain_sum;
  logic [LEN_W:0]    resize_sum;
  logic [CODE_W-1:0] status_nxt;
  logic [LEN_W-1:0]  data_nxt;
  logic              wr_hdr;
  logic [LEN_W-1:0]  wr_pos;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LEN_W-1:0]  mem_wdata;
  logic [AW-1:0]     mem_raddr;

  // register value above the buffer size acts as the buffer size
  assign cap = (cap_r > CAP_LIM) ? CAP_LIM : cap_r;
  assign off_u = off_r[LEN_W-1:0];

  assign alloc_sum  = {2'b00, top_r} + {2'b00, HDR} + {2'b00, size_r};
  assign chain_sum  = {1'b0, off_u} + {1'b0, rdata_r};
  assign resize_sum = {1'b0, off_u} + {1'b0, size_r};

  always_comb begin
    status_nxt = STS_OK;
    data_nxt   = '0;
    top_nxt    = top_r;
    wr_hdr     = 1'b0;
    wr_pos     = top_r;
    case (cmd_code_t'(cmd_r))
      CMD_ALLOC: begin
        if (alloc_sum > {2'b00, cap}) begin
          status_nxt = STS_NO_ROOM;
        end else begin
          wr_hdr   = 1'b1;
          data_nxt = top_r + HDR;
          top_nxt  = alloc_sum[LEN_W-1:0];
        end
      end
      CMD_RESET: begin
        top_nxt = '0;
      end
      default: begin
        // resize and free
        if (off_r[OFF_W-1] || off_u >= cap) begin
          status_nxt = STS_NOT_OWN;
        end else if (off_u < HDR) begin
          status_nxt = STS_NOT_LAST;
        end else if (chain_sum != {1'b0, top_r}) begin
          status_nxt = STS_NOT_LAST;
        end else if (cmd_code_t'(cmd_r) == CMD_RESIZE) begin
          if (resize_sum > {1'b0, cap}) begin
            status_nxt = STS_NO_ROOM;
          end else begin
            wr_hdr   = 1'b1;
            wr_pos   = off_u - HDR;
            top_nxt  = resize_sum[LEN_W-1:0];
            data_nxt = off_u;
          end
        end else begin
          top_nxt = off_u - HDR;
        end
      end
    endcase
  end

  assign cap_nxt     = cfg_wr_en ? cfg_wr_data : cap_r;
  assign clr_cnt_nxt = dp_cmd.clear ? clr_cnt_r + 1'b1 : clr_cnt_r;
  assign dp_sts.clear_done = dp_cmd.clear && (clr_cnt_r == CLR_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      top_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      cap_r     <= cap_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (dp_cmd.exec) begin
        top_r <= top_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r  <= in_cmd;
      size_r <= in_slice_size;
      off_r  <= in_slice_offset;
    end
    if (dp_cmd.exec) begin
      status_r  <= status_nxt;
      data_r    <= data_nxt;
      top_out_r <= top_nxt;
    end
  end

  // header store: one write port, one registered read port
  assign mem_we    = dp_cmd.clear || (dp_cmd.exec && wr_hdr);
  assign mem_waddr = dp_cmd.clear ? clr_cnt_r : AW'(wr_pos);
  assign mem_wdata = dp_cmd.clear ? '0 : size_r;
  // header sits just below the slice data
  assign mem_raddr = AW'(in_slice_offset[LEN_W-1:0] - HDR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      rdata_r <= hdr_mem[mem_raddr];
    end
  end

  assign out_status      = status_r;
  assign out_data_offset = data_r;
  assign out_top_index   = top_out_r;

endmodule

>>> rtl/lifo_stack_allocator_top.sv
// ----------------------------------------------------------------------------
// lifo_stack_allocator_top
// LIFO stack allocator: top index plus a store of slice length headers
// ----------------------------------------------------------------------------
// Input stream: one word per command, kind in in_tuser, size and offset in
// in_tdata. Output stream: one word per command, status in out_tuser, data
// offset and new top index in out_tdata. cfg_wr_en/cfg_wr_data set the
// usable capacity (reset 65536); the user must write it only while the
// block is idle, which the block itself does not enforce. The accept cycle
// issues the header read to the registered read port of the store; the
// execute step, once the output register can take the word, checks it,
// writes the header back if needed, moves the top and loads the output
// register. A new word is taken in the cycle after the previous command
// completes. Reset zeroes the top and sets the capacity register to 65536,
// then sweeps the header store to zero one entry a cycle, all BUFFER_BYTES
// entries (65536 by default), with in_tready low. If the receiver stalls,
// the pending result holds in the output register; one more word is
// accepted and waits in the execute step until the output register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lifo_stack_allocator_top import lsa_pkg::*; #(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [LEN_W-1:0]       cfg_wr_data,    // buffer_capacity
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,       // slice_size[16:0], slice_offset[34:17]
  input  logic [CODE_W-1:0]      in_tuser,       // cmd[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,      // data_offset[16:0], top_index[33:17]
  output logic [CODE_W-1:0]      out_tuser       // status[1:0]
);

  dp_cmd_t          dp_cmd;
  dp_sts_t          dp_sts;
  logic [LEN_W-1:0] data_offset;
  logic [LEN_W-1:0] top_index;

  lsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .dp_sts     (dp_sts),
    .dp_cmd     (dp_cmd)
  );

  lsa_dp #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .dp_cmd          (dp_cmd),
    .dp_sts          (dp_sts),
    .in_cmd          (in_tuser),
    .in_slice_size   (in_tdata[LEN_W-1:0]),
    .in_slice_offset (in_tdata[LEN_W+OFF_W-1:LEN_W]),
    .out_status      (out_tuser),
    .out_data_offset (data_offset),
    .out_top_index   (top_index)
  );

  assign out_tdata = {{(OUT_TDATA_W - 2*LEN_W){1'b0}}, top_index, data_offset};

  `ASSERT_NEVER(a_no_overwrite, dp_cmd.exec && out_tvalid && !out_tready, "result overwritten")
  `ASSERT_NEVER(a_no_accept_in_clear, dp_cmd.clear && in_tready, "word accepted during clear")
  `ASSERT_CLK(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "accepted while busy")
  `ASSERT_CLK(a_exec_gives_result, dp_cmd.exec |=> out_tvalid, "execute without result")

endmodule

>>> test/stack_alloc_checker.sv
// ----------------------------------------------------------------------------
// stack_alloc_checker
// Watches the command and result streams of the lifo stack allocator,
// keeps its own copy of the top index, the slice length headers and the
// capacity, works out the result of every accepted command and compares it
// field by field with the word the block returns
// ----------------------------------------------------------------------------
module stack_alloc_checker import lsa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [LEN_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,     // slice_size[16:0], slice_offset[34:17]
  input  logic [CODE_W-1:0]      in_tuser,     // cmd[1:0]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,    // data_offset[16:0], top_index[33:17]
  input  logic [CODE_W-1:0]      out_tuser,    // status[1:0]
  output int                     fail_count,
  output int                     pending,
  output int                     checked,
  output int                     granted
);

  localparam int HDR_B = HEADER_BYTES_DEF;
  localparam int BUF_B = BUFFER_BYTES_DEF;

  typedef struct packed {
    sts_code_t        status;
    logic [LEN_W-1:0] data_offset;
    logic [LEN_W-1:0] top_index;
  } alloc_result_t;

  logic [LEN_W-1:0] capacity_reg;
  logic [LEN_W-1:0] top_reg;
  logic [LEN_W-1:0] slice_len [BUF_B];   // header store, keyed by header byte offset
  alloc_result_t    expected_results [$];

  // applies one command to the local state and returns the word it should give
  function automatic alloc_result_t alloc_step(cmd_code_t cmd, logic [LEN_W-1:0] size,
                                               logic signed [OFF_W-1:0] offset);
    alloc_result_t r;
    int cap;
    int top;
    int sz;
    int off;
    int len;
    cap = (int'(capacity_reg) > BUF_B) ? BUF_B : int'(capacity_reg);
    top = int'(top_reg);
    sz = int'(size);
    off = offset;
    r.status = STS_OK;
    r.data_offset = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (top + HDR_B + sz > cap) begin
          r.status = STS_NO_ROOM;
        end else begin
          slice_len[top] = size;
          r.data_offset = LEN_W'(top + HDR_B);
          top = top + HDR_B + sz;
        end
      end
      CMD_RESET: begin
        top = 0;
      end
      default: begin
        if (off < 0 || off >= cap) begin
          r.status = STS_NOT_OWN;
        end else if (off < HDR_B) begin
          // no room for a header in front of it
          r.status = STS_NOT_LAST;
        end else begin
          len = int'(slice_len[off - HDR_B]);
          if (off + len != top) begin
            r.status = STS_NOT_LAST;
          end else if (cmd == CMD_RESIZE) begin
            if (off + sz > cap) begin
              r.status = STS_NO_ROOM;
            end else begin
              slice_len[off - HDR_B] = size;
              top = off + sz;
              r.data_offset = LEN_W'(off);
            end
          end else begin
            top = off - HDR_B;
          end
        end
      end
    endcase
    top_reg = LEN_W'(top);
    r.top_index = top_reg;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    alloc_result_t want;
    if (!rst_n) begin
      capacity_reg = CAP_RESET;
      top_reg = '0;
      foreach (slice_len[i]) slice_len[i] = '0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) capacity_reg = cfg_wr_data;
      // results first: a word accepted at this edge cannot already be answered
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: tdata %h tuser %0d", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (want.status == STS_OK) granted++;
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[0 +: LEN_W] !== want.data_offset) begin
            $error("data_offset: expected %0d, got %0d", want.data_offset,
                   out_tdata[0 +: LEN_W]);
            fail_count++;
          end
          if (out_tdata[LEN_W +: LEN_W] !== want.top_index) begin
            $error("top_index: expected %0d, got %0d", want.top_index,
                   out_tdata[LEN_W +: LEN_W]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(alloc_step(cmd_code_t'(in_tuser), in_tdata[0 +: LEN_W],
                                              in_tdata[LEN_W +: OFF_W]));
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> test/lifo_stack_allocator_top_tb.sv
// ----------------------------------------------------------------------------
// lifo_stack_allocator_top_tb
// Drives the lifo stack allocator with a directed set of edge commands and
// then with randomized alloc/resize/free/reset sequences over a range of
// capacities, with random gaps on both streams; the checker beside the
// block predicts and compares every result word
// ----------------------------------------------------------------------------
module lifo_stack_allocator_top_tb;
  import lsa_pkg::*;

  localparam int HDR_B = HEADER_BYTES_DEF;
  localparam int BUF_B = BUFFER_BYTES_DEF;
  localparam int N_PHASES = 12;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;       // slice_size[16:0], slice_offset[34:17]
  logic [CODE_W-1:0]      in_tuser = '0;       // cmd[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;           // data_offset[16:0], top_index[33:17]
  logic [CODE_W-1:0]      out_tuser;           // status[1:0]

  int chk_fail;
  int chk_pending;
  int chk_checked;
  int chk_granted;

  // stimulus side view of the stack, only used to aim commands
  int gen_cap = BUF_B;
  int gen_top = 0;
  int slice_start [$];

  bit no_idle = 1'b0;
  int sent [4];
  int n_caps = 0;

  int phase_cap [N_PHASES] = '{0, 8, 9, 24, 300, 1024, 65536, 40, 4096, 65535, -1, 65536};
  int phase_words [N_PHASES] = '{30, 30, 40, 60, 150, 180, 220, 80, 180, 150, 120, 160};
  bit phase_keep [N_PHASES] = '{0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lifo_stack_allocator_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  stack_alloc_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (chk_fail),
    .pending     (chk_pending),
    .checked     (chk_checked),
    .granted     (chk_granted)
  );

  // valid stays high from one word to the next unless a gap is drawn
  task automatic send_word(input cmd_code_t cmd, input int size, input int off);
    int gap;
    gap = no_idle ? 0 : $urandom_range(7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= IN_TDATA_W'({off[OFF_W-1:0], size[LEN_W-1:0]});
    do @(posedge clk); while (!in_tready);
    sent[cmd]++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input int value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[LEN_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gen_cap = (value > BUF_B) ? BUF_B : value;
    n_caps++;
  endtask

  // mostly well-formed stack traffic aimed at the last slice, some noise
  task automatic random_word();
    cmd_code_t cmd;
    int r;
    int pick;
    int sz;
    int off;
    int depth;
    int lim;
    depth = slice_start.size();
    lim = (gen_cap / 8 < 16) ? 16 : gen_cap / 8;
    r = $urandom_range(99);
    pick = $urandom_range(9);
    sz = $urandom_range(lim);
    off = (depth != 0) ? slice_start[depth-1] : $urandom_range(gen_cap + HDR_B);
    if (r < 40) begin
      cmd = CMD_ALLOC;
      if (pick == 7) sz = $urandom_range(BUF_B);
      else if (pick == 8) sz = gen_cap - gen_top - HDR_B;
      else if (pick == 9) sz = gen_cap - gen_top - HDR_B + 1;
    end else if (r < 60) begin
      cmd = CMD_FREE;
    end else if (r < 75) begin
      cmd = CMD_RESIZE;
      if (pick == 7) sz = $urandom_range(BUF_B);
      else if (pick == 8) sz = gen_cap - off;
      else if (pick == 9) sz = gen_cap - off + 1;
    end else if (r < 85) begin
      // an older slice, or somewhere inside the stack
      cmd = ($urandom_range(1) != 0) ? CMD_FREE : CMD_RESIZE;
      off = (depth > 1) ? slice_start[$urandom_range(depth - 2)] : $urandom_range(gen_top);
    end else if (r < 96) begin
      cmd = ($urandom_range(1) != 0) ? CMD_FREE : CMD_RESIZE;
      off = $urandom_range(3 * BUF_B - 1) - BUF_B;
      sz = $urandom_range(BUF_B);
    end else begin
      cmd = CMD_RESET;
      off = $urandom_range(3 * BUF_B - 1) - BUF_B;
    end
    if (sz < 0) sz = 0;
    if (sz > BUF_B) sz = BUF_B;
    case (cmd)
      CMD_ALLOC: begin
        if (gen_top + HDR_B + sz <= gen_cap) begin
          slice_start.push_back(gen_top + HDR_B);
          gen_top = gen_top + HDR_B + sz;
        end
      end
      CMD_RESET: begin
        gen_top = 0;
        slice_start.delete();
      end
      default: begin
        if (depth != 0 && off == slice_start[depth-1] && off < gen_cap) begin
          if (cmd == CMD_FREE) begin
            void'(slice_start.pop_back());
            gen_top = off - HDR_B;
          end else if (off + sz <= gen_cap) begin
            gen_top = off + sz;
          end
        end
      end
    endcase
    send_word(cmd, sz, off);
  endtask

  initial begin : drain
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty stack, foreign offsets, header region, exact fills
    send_word(CMD_FREE, 0, 8);
    send_word(CMD_RESIZE, 5, -1);
    send_word(CMD_FREE, 0, -65536);
    send_word(CMD_RESIZE, 65536, 131071);
    send_word(CMD_FREE, 0, 65536);
    send_word(CMD_RESIZE, 1, 0);
    send_word(CMD_FREE, 0, 7);
    send_word(CMD_ALLOC, 0, 0);
    send_word(CMD_FREE, 0, 8);
    send_word(CMD_ALLOC, 65536, 0);
    send_word(CMD_ALLOC, 65528, 0);
    send_word(CMD_ALLOC, 0, 0);
    send_word(CMD_RESIZE, 65536, 8);
    send_word(CMD_RESIZE, 65528, 8);
    send_word(CMD_RESIZE, 100, 8);
    send_word(CMD_ALLOC, 50, 131071);
    send_word(CMD_FREE, 0, 8);
    send_word(CMD_RESIZE, 0, 116);
    send_word(CMD_FREE, 0, 116);
    send_word(CMD_FREE, 0, 8);
    send_word(CMD_ALLOC, 17, -1);
    send_word(CMD_RESET, 65536, -65536);
    // stale header left by the index reset
    send_word(CMD_FREE, 0, 8);
    send_word(CMD_ALLOC, 1, 0);
    send_word(CMD_FREE, 0, 8);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      write_capacity((phase_cap[p] < 0) ? $urandom_range(BUF_B) : phase_cap[p]);
      // a kept phase runs against a capacity below the current top
      if (!phase_keep[p]) begin
        send_word(CMD_RESET, 0, 0);
        gen_top = 0;
        slice_start.delete();
      end
      for (int i = 0; i < phase_words[p]; i++) begin
        if (i % 64 == 0) no_idle = ($urandom_range(3) == 0);
        random_word();
      end
    end
    no_idle = 1'b0;
    wait_drained();

    $display("covered %0d commands (alloc %0d, resize %0d, free %0d, index reset %0d)",
             sent[CMD_ALLOC] + sent[CMD_RESIZE] + sent[CMD_FREE] + sent[CMD_RESET],
             sent[CMD_ALLOC], sent[CMD_RESIZE], sent[CMD_FREE], sent[CMD_RESET]);
    $display("over %0d capacity settings; %0d result words compared, %0d with ok status",
             n_caps, chk_checked, chk_granted);
    if (chk_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // the timeout leaves room for the header store sweep after reset and the traffic
  initial begin : watchdog
    #4000000;
    $display("timeout waiting for the allocator");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
